/* sv/tach_pkg.sv */
package tach_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int CORDIC_STEPS = 16;

    localparam int SQ_W    = 2 * SAMPLE_BITS;
    localparam int RAD_W   = SQ_W + 16;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int VEC_W   = SAMPLE_BITS + 12;
    localparam int ZACC_W  = 33;
    localparam int ANG_W   = ZACC_W - 16;
    localparam int CORDIC_LAT = CORDIC_STEPS + 2;
    localparam int DATA_IN_W  = 80;
    localparam int DATA_OUT_W = 48;

    localparam logic signed [ZACC_W-1:0] QUARTER_TURN = 33'sd589824000;
    localparam logic signed [ZACC_W-1:0] HALF_ANGLE_ONE = 33'sd32768;

    localparam logic signed [ZACC_W-1:0] ATAN_TAB [0:23] = '{
        33'sd294912000, 33'sd174096719, 33'sd91987925, 33'sd46694507,
        33'sd23437865, 33'sd11730358, 33'sd5866610, 33'sd2933484,
        33'sd1466764, 33'sd733385, 33'sd366693, 33'sd183346,
        33'sd91673, 33'sd45837, 33'sd22918, 33'sd11459,
        33'sd5730, 33'sd2865, 33'sd1432, 33'sd716,
        33'sd358, 33'sd179, 33'sd90, 33'sd45
    };

    localparam logic signed [15:0] DECL_RESET = 16'sd360;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] ax;
        logic signed [SAMPLE_BITS-1:0] ay;
        logic signed [SAMPLE_BITS-1:0] az;
        logic signed [SAMPLE_BITS-1:0] mx;
        logic signed [SAMPLE_BITS-1:0] my;
    } sample_t;

endpackage

/* sv/tilt_and_compass_heading_core.sv */
// A request passes two input registers, 24 square-root steps, 18 CORDIC stages and the output register.
// Throughput: one request per cycle while the output is taken; a result waiting
// at the output holds the whole pipeline and drops s_axis_tready until it is taken.
// Reset: rst_n, asynchronous active low, clears all valid bits and loads
// the declination register with 360.
module tilt_and_compass_heading_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // accel_x, accel_y, accel_z, mag_x, mag_y
    input  logic [tach_pkg::DATA_IN_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // roll_angle, pitch_angle, heading_angle, zero pad
    output logic [tach_pkg::DATA_OUT_W-1:0]     m_axis_tdata,
    input  logic                                cfg_we,
    input  logic [15:0]                         cfg_wdata
);
    import tach_pkg::*;

    localparam int NV = 3 + ROOT_W + CORDIC_LAT;

    logic                 en;
    logic [NV-1:0]        vld_reg;
    logic signed [15:0]   decl_reg;

    sample_t              smp_in;
    sample_t              smp_reg;
    sample_t              dly_reg [0:ROOT_W];
    logic [SQ_W-1:0]      ay2_reg;
    logic [SQ_W-1:0]      az2_reg;
    logic [SQ_W-1:0]      sum_reg;
    logic signed [SQ_W-1:0] ay_prod;
    logic signed [SQ_W-1:0] az_prod;
    logic [ROOT_W-1:0]    mag;
    logic [CORDIC_LAT-1:0] myz_reg;
    logic [CORDIC_LAT-1:0] mxp_reg;
    sample_t              cs;

    logic signed [VEC_W-1:0] roll_y, roll_x, pitch_y, pitch_x, head_y, head_x;
    logic signed [ANG_W-1:0] roll_ang, pitch_ang, head_ang;

    logic signed [15:0]   roll_c;
    logic signed [14:0]   pitch_c;
    logic signed [17:0]   head_c;
    logic signed [17:0]   diff;
    logic signed [17:0]   wrap;
    logic [DATA_OUT_W-1:0] out_next;
    logic [DATA_OUT_W-1:0] out_reg;

    assign en = !vld_reg[NV-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[NV-1];
    assign m_axis_tdata  = out_reg;

    assign smp_in.ax = s_axis_tdata[SAMPLE_BITS-1:0];
    assign smp_in.ay = s_axis_tdata[16 +: SAMPLE_BITS];
    assign smp_in.az = s_axis_tdata[32 +: SAMPLE_BITS];
    assign smp_in.mx = s_axis_tdata[48 +: SAMPLE_BITS];
    assign smp_in.my = s_axis_tdata[64 +: SAMPLE_BITS];

    assign ay_prod = smp_in.ay * smp_in.ay;
    assign az_prod = smp_in.az * smp_in.az;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            decl_reg <= DECL_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                decl_reg <= cfg_wdata;
            end
            if (en)
            begin
                vld_reg <= {vld_reg[NV-2:0], s_axis_tvalid};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            smp_reg <= smp_in;
            ay2_reg <= ay_prod;
            az2_reg <= az_prod;
            sum_reg <= ay2_reg + az2_reg;
            dly_reg[0] <= smp_reg;
            for (int j = 1; j <= ROOT_W; j++)
            begin
                dly_reg[j] <= dly_reg[j-1];
            end
            myz_reg <= {myz_reg[CORDIC_LAT-2:0], cs.my == '0};
            mxp_reg <= {mxp_reg[CORDIC_LAT-2:0], !cs.mx[SAMPLE_BITS-1] && cs.mx != '0};
            out_reg <= out_next;
        end
    end

    tach_sqrt u_sqrt (
        .clk      (clk),
        .en       (en),
        .radicand ({sum_reg, 16'd0}),
        .root     (mag)
    );

    assign cs = dly_reg[ROOT_W];

    assign roll_y  = VEC_W'(cs.ay) <<< 8;
    assign roll_x  = VEC_W'(cs.az) <<< 8;
    assign pitch_y = -(VEC_W'(cs.ax) <<< 8);
    assign pitch_x = VEC_W'(mag);
    assign head_y  = -(VEC_W'(cs.mx) <<< 8);
    assign head_x  = VEC_W'(cs.my) <<< 8;

    tach_cordic u_roll (
        .clk (clk), .en (en), .y_in (roll_y), .x_in (roll_x), .angle (roll_ang)
    );

    tach_cordic u_pitch (
        .clk (clk), .en (en), .y_in (pitch_y), .x_in (pitch_x), .angle (pitch_ang)
    );

    tach_cordic u_head (
        .clk (clk), .en (en), .y_in (head_y), .x_in (head_x), .angle (head_ang)
    );

    always_comb
    begin
        if (roll_ang > 17'sd18000)
            roll_c = 16'sd18000;
        else if (roll_ang < -17'sd18000)
            roll_c = -16'sd18000;
        else
            roll_c = roll_ang[15:0];

        if (pitch_ang > 17'sd9000)
            pitch_c = 15'sd9000;
        else if (pitch_ang < -17'sd9000)
            pitch_c = -15'sd9000;
        else
            pitch_c = pitch_ang[14:0];

        if (myz_reg[CORDIC_LAT-1])
            head_c = mxp_reg[CORDIC_LAT-1] ? 18'sd18000 : 18'sd0;
        else if (head_ang > 17'sd18000)
            head_c = 18'sd18000;
        else if (head_ang < -17'sd18000)
            head_c = -18'sd18000;
        else
            head_c = 18'(head_ang);

        diff = head_c - 18'(decl_reg);
        if (diff < -18'sd36000)
            wrap = diff + 18'sd72000;
        else if (diff < 18'sd0)
            wrap = diff + 18'sd36000;
        else if (diff >= 18'sd36000)
            wrap = diff - 18'sd36000;
        else
            wrap = diff;

        out_next = {1'b0, wrap[15:0], pitch_c, roll_c};
    end

endmodule

/* sv/tach_sqrt.sv */
module tach_sqrt (
    input  logic                         clk,
    input  logic                         en,
    input  logic [tach_pkg::RAD_W-1:0]   radicand,
    output logic [tach_pkg::ROOT_W-1:0]  root
);
    import tach_pkg::*;

    localparam int REM_W = ROOT_W + 2;

    logic [RAD_W-1:0]  n_reg    [0:ROOT_W-1];
    logic [REM_W-1:0]  rem_reg  [0:ROOT_W-1];
    logic [ROOT_W-1:0] root_reg [0:ROOT_W-1];

    for (genvar i = 0; i < ROOT_W; i++) begin : g_step
        logic [RAD_W-1:0]  n_in;
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [REM_W+1:0]  rem_sh;
        logic [REM_W+1:0]  trial;
        logic              take;

        if (i == 0) begin : g_first
            assign n_in    = radicand;
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else begin : g_next
            assign n_in    = n_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
        end

        assign rem_sh = {rem_in, n_in[2*(ROOT_W-1-i)+1 -: 2]};
        assign trial  = {2'b00, root_in, 2'b01};
        assign take   = rem_sh >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[i]    <= n_in;
                rem_reg[i]  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
                root_reg[i] <= {root_in[ROOT_W-2:0], take};
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

/* sv/tach_cordic.sv */
module tach_cordic (
    input  logic                               clk,
    input  logic                               en,
    input  logic signed [tach_pkg::VEC_W-1:0]  y_in,
    input  logic signed [tach_pkg::VEC_W-1:0]  x_in,
    output logic signed [tach_pkg::ANG_W-1:0]  angle
);
    import tach_pkg::*;

    logic signed [VEC_W-1:0]  x_reg [0:CORDIC_STEPS];
    logic signed [VEC_W-1:0]  y_reg [0:CORDIC_STEPS];
    logic signed [ZACC_W-1:0] z_reg [0:CORDIC_STEPS];
    logic                     zero_reg [0:CORDIC_STEPS];
    logic signed [ZACC_W-1:0] z_round;
    logic signed [ANG_W-1:0]  angle_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in[VEC_W-1])
            begin
                if (!y_in[VEC_W-1])
                begin
                    x_reg[0] <= y_in;
                    y_reg[0] <= -x_in;
                    z_reg[0] <= QUARTER_TURN;
                end
                else
                begin
                    x_reg[0] <= -y_in;
                    y_reg[0] <= x_in;
                    z_reg[0] <= -QUARTER_TURN;
                end
            end
            else
            begin
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
                z_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i][VEC_W-1])
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ATAN_TAB[i];
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ATAN_TAB[i];
                end
            end
        end
    end

    assign z_round = z_reg[CORDIC_STEPS] + HALF_ANGLE_ONE;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= zero_reg[CORDIC_STEPS] ? '0 : z_round[ZACC_W-1:16];
        end
    end

    assign angle = angle_reg;

endmodule
